### hdl/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, register indexes and CORDIC constants of the scan segmenter.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam logic [29:0] GainQ30 = 30'd652032874;
    localparam logic [10:0] SegMax = 11'd2047;

    typedef enum logic [2:0] {
        REG_POSE_X = 3'd0,
        REG_POSE_Y = 3'd1,
        REG_YAW    = 3'd2,
        REG_START  = 3'd3,
        REG_STEP   = 3'd4,
        REG_TOL    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        range_valid;
        logic        end_of_scan;
    } t_in_word;

    typedef struct packed {
        logic               result_kind;
        logic signed [23:0] global_x_mm;
        logic signed [23:0] global_y_mm;
        logic [10:0]        segment_number;
        logic               starts_segment;
        logic [11:0]        segments_total;
        logic               wrap_merge;
        logic               too_few_points;
        logic               last_of_run;
    } t_out_word;

    // Queue entry between the front end and the projection engine.
    typedef struct packed {
        logic [15:0] range_mm;
        logic        range_valid;
        logic        end_of_scan;
        logic [31:0] angle;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_FINISH,
        ST_COMPARE,
        ST_EMIT_POINT,
        ST_EMIT_SUMMARY
    } t_state;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] tab [32];
        tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                32'd42667331, 32'd21354465, 32'd10680350, 32'd5340245,
                32'd2670675, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
                32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
                32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
                32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
        return tab[idx];
    endfunction

endpackage

### hdl/lss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_front
// Accepts samples, tracks the beam index and queues each word with its angle.
// ----------------------------------------------------------------------------
module lss_front #(
    parameter int unsigned IDX_W   = 11,
    parameter int unsigned SAMPLES = 2048
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  lss_pkg::t_in_word i_data,
    input  logic [31:0]     i_yaw,
    input  logic [31:0]     i_start,
    input  logic [31:0]     i_step,
    output logic            o_valid,
    input  logic            i_stall,
    output lss_pkg::t_job   o_job
);
    import lss_pkg::*;

    logic [IDX_W-1:0] r_beam, n_beam;
    logic [31:0]      r_acc, n_acc;   // beam_index * step, kept incrementally
    t_job             r_q [2];
    logic [1:0]       r_cnt;
    logic             r_wp, r_rp;
    logic             w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && !i_stall;
    assign o_job   = r_q[r_rp];

    always_comb begin
        n_beam = r_beam;
        n_acc  = r_acc;
        if (w_push) begin
            if (i_data.end_of_scan || (r_beam == IDX_W'(SAMPLES - 1))) begin
                n_beam = '0;
                n_acc  = '0;
            end else begin
                n_beam = r_beam + 1'b1;
                n_acc  = r_acc + i_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam <= '0;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
        end else begin
            r_beam <= n_beam;
            r_acc  <= n_acc;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{range_mm:    i_data.range_mm,
                           range_valid: i_data.range_valid,
                           end_of_scan: i_data.end_of_scan,
                           angle:       i_start + r_acc + i_yaw};
        end
    end
endmodule

### hdl/lss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_back
// Iterative CORDIC projection, segment compare and result output register.
// ----------------------------------------------------------------------------
module lss_back #(
    parameter int unsigned FRAC = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lss_pkg::t_job      i_job,
    input  logic signed [23:0] i_pose_x,
    input  logic signed [23:0] i_pose_y,
    input  logic [15:0]        i_tol,
    output logic               o_valid,
    input  logic               i_stall,
    output lss_pkg::t_out_word o_data
);
    import lss_pkg::*;

    localparam int unsigned STEPS = FRAC + 2;
    localparam int unsigned VW = 16 + FRAC + 4;   // CORDIC datapath width

    t_state r_state, n_state;
    t_job   r_job;
    logic signed [VW-1:0] r_x, r_y;
    logic signed [32:0]   r_z;
    logic [4:0]           r_i;
    logic signed [23:0]   r_gx, r_gy, r_fx, r_fy, r_px, r_py;
    logic [1:0]           r_seen;
    logic [10:0]          r_seg;
    logic                 r_starts;
    logic                 r_ovalid, n_ovalid;
    t_out_word            r_out, n_out;
    t_out_word            w_pt, w_sm;

    logic signed [VW-1:0] w_x0, w_xs, w_ys, w_rx, w_ry;
    logic [46:0]          w_prod;
    logic [31:0]          w_ang;
    logic                 w_flip;
    logic signed [25:0]   w_sx, w_sy;
    logic signed [24:0]   w_dx, w_dy;
    logic [50:0]          w_d2;
    logic [31:0]          w_t2;
    logic                 w_far;
    logic signed [24:0]   w_ax, w_ay, w_bx, w_by;

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    assign w_prod = {31'd0, i_job.range_mm} * {17'd0, GainQ30};
    assign w_x0   = VW'(w_prod >> (30 - FRAC));
    assign w_flip = (i_job.angle + 32'h4000_0000) >= 32'h8000_0000;
    assign w_ang  = w_flip ? i_job.angle + 32'h8000_0000 : i_job.angle;
    assign w_xs   = r_y >>> r_i;
    assign w_ys   = r_x >>> r_i;
    assign w_rx   = (r_x + (VW'(1) <<< (FRAC - 1))) >>> FRAC;
    assign w_ry   = (r_y + (VW'(1) <<< (FRAC - 1))) >>> FRAC;
    assign w_sx   = 26'(w_rx) + 26'(i_pose_x);
    assign w_sy   = 26'(w_ry) + 26'(i_pose_y);

    // Distance test: new point against prior one, or last against first.
    always_comb begin
        if (r_state == ST_COMPARE) begin
            w_ax = 25'(r_gx); w_ay = 25'(r_gy); w_bx = 25'(r_px); w_by = 25'(r_py);
        end else begin
            w_ax = 25'(r_px); w_ay = 25'(r_py); w_bx = 25'(r_fx); w_by = 25'(r_fy);
        end
    end
    assign w_dx  = w_ax - w_bx;
    assign w_dy  = w_ay - w_by;
    assign w_d2  = 51'(w_dx * w_dx) + 51'(w_dy * w_dy);
    assign w_t2  = i_tol * i_tol;
    assign w_far = w_d2 >= 51'(w_t2);

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607)       return 24'sh7FFFFF;
        else if (v < -26'sd8388608) return 24'sh800000;
        else                        return v[23:0];
    endfunction

    // Point and summary words as they would leave the output register.
    always_comb begin
        w_pt = '0;
        w_pt.global_x_mm    = r_gx;
        w_pt.global_y_mm    = r_gy;
        w_pt.segment_number = r_seg;
        w_pt.starts_segment = r_starts;
        w_pt.last_of_run    = !r_job.end_of_scan;
        w_sm = '0;
        w_sm.result_kind = 1'b1;
        w_sm.last_of_run = 1'b1;
        if (r_seen != 2'd2) begin
            w_sm.too_few_points = 1'b1;
        end else if (r_seg != 11'd0 && !w_far) begin
            w_sm.wrap_merge     = 1'b1;
            w_sm.segments_total = {1'b0, r_seg};
        end else begin
            w_sm.segments_total = {1'b0, r_seg} + 12'd1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        n_out    = r_out;
        unique case (r_state)
            ST_IDLE: if (i_valid) begin
                if (i_job.range_valid) n_state = ST_ROTATE;
                else if (i_job.end_of_scan) n_state = ST_EMIT_SUMMARY;
            end
            ST_ROTATE:       if (r_i == 5'(STEPS - 1)) n_state = ST_FINISH;
            ST_FINISH:       n_state = ST_COMPARE;
            ST_COMPARE:      n_state = ST_EMIT_POINT;
            ST_EMIT_POINT:   if (!r_ovalid || !i_stall) begin
                n_state  = r_job.end_of_scan ? ST_EMIT_SUMMARY : ST_IDLE;
                n_ovalid = 1'b1;
                n_out    = w_pt;
            end
            ST_EMIT_SUMMARY: if (!r_ovalid || !i_stall) begin
                n_state  = ST_IDLE;
                n_ovalid = 1'b1;
                n_out    = w_sm;
            end
            default:         n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_out    <= '0;
            r_seen   <= '0;
            r_seg    <= '0;
            r_fx <= '0; r_fy <= '0; r_px <= '0; r_py <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_out    <= n_out;
            unique case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_x   <= w_flip ? -w_x0 : w_x0;
                    r_y   <= '0;
                    r_z   <= 33'(signed'(w_ang));
                    r_i   <= '0;
                end
                ST_ROTATE: begin
                    if (!r_z[32]) begin
                        r_x <= r_x - w_xs; r_y <= r_y + w_ys;
                        r_z <= r_z - 33'(atan_entry(r_i));
                    end else begin
                        r_x <= r_x + w_xs; r_y <= r_y - w_ys;
                        r_z <= r_z + 33'(atan_entry(r_i));
                    end
                    r_i <= r_i + 1'b1;
                end
                ST_FINISH: begin
                    r_gx <= sat24(w_sx);
                    r_gy <= sat24(w_sy);
                end
                ST_COMPARE: begin
                    if (r_seen == 2'd0) begin
                        r_starts <= 1'b1;
                        r_seg    <= '0;
                        r_fx <= r_gx; r_fy <= r_gy;
                    end else begin
                        r_starts <= w_far;
                        if (w_far && r_seg < SegMax) r_seg <= r_seg + 1'b1;
                    end
                    r_px <= r_gx; r_py <= r_gy;
                    if (r_seen != 2'd2) r_seen <= r_seen + 1'b1;
                end
                ST_EMIT_SUMMARY: if (!r_ovalid || !i_stall) begin
                    r_seen <= '0;
                    r_seg  <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule

### hdl/lidar_scan_segmenter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_segmenter_unit
// Projects lidar beams to global points and splits the scan into segments.
// ----------------------------------------------------------------------------
// A valid sample passes the one-step-per-cycle CORDIC rotator in the back end,
// which takes no new sample until it is done; a missing sample skips it, and
// an end of scan adds a summary word. A two-entry queue sits between the front
// end that tags each word with its beam angle and the back end, and the result
// register lets the next sample start while a word waits.
// Registers are to be written only while no sample is in flight.
module lidar_scan_segmenter_unit #(
    parameter int unsigned MAX_SCAN_SAMPLES   = 2048,
    parameter int unsigned TRIG_FRACTION_BITS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lss_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output lss_pkg::t_out_word o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lss_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_SCAN_SAMPLES);

    logic signed [23:0] r_pose_x, r_pose_y;
    logic [31:0]        r_yaw, r_start, r_step;
    logic [15:0]        r_tol;
    logic               w_qvalid, w_qstall;
    t_job               w_job;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x <= '0; r_pose_y <= '0; r_yaw <= '0;
            r_start  <= '0; r_step   <= '0; r_tol <= 16'd175;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_POSE_X: r_pose_x <= pwdata[23:0];
                REG_POSE_Y: r_pose_y <= pwdata[23:0];
                REG_YAW:    r_yaw    <= pwdata;
                REG_START:  r_start  <= pwdata;
                REG_STEP:   r_step   <= pwdata;
                REG_TOL:    r_tol    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_POSE_X: prdata = {{8{r_pose_x[23]}}, r_pose_x};
            REG_POSE_Y: prdata = {{8{r_pose_y[23]}}, r_pose_y};
            REG_YAW:    prdata = r_yaw;
            REG_START:  prdata = r_start;
            REG_STEP:   prdata = r_step;
            REG_TOL:    prdata = {16'd0, r_tol};
            default:    prdata = '0;
        endcase
    end

    lss_front #(.IDX_W(IDX_W), .SAMPLES(MAX_SCAN_SAMPLES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .i_yaw(r_yaw), .i_start(r_start), .i_step(r_step),
        .o_valid(w_qvalid), .i_stall(w_qstall), .o_job(w_job)
    );

    lss_back #(.FRAC(TRIG_FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qvalid), .o_stall(w_qstall), .i_job(w_job),
        .i_pose_x(r_pose_x), .i_pose_y(r_pose_y), .i_tol(r_tol),
        .o_valid, .i_stall, .o_data
    );
endmodule

### bench/lss_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_result_checker
// Watches the sample and result channels and the register port of the scan
// segmenter, predicts every result word from the accepted samples and the
// register values, and compares each accepted result word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module lss_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  lss_pkg::t_in_word  i_data,
    input  logic               o_valid,
    input  logic               i_stall,
    input  lss_pkg::t_out_word o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_errors,
    output int                 o_pending
);
    import lss_pkg::*;

    localparam int FracBits = 15;
    localparam int RotSteps = FracBits + 2;
    localparam int ScanLen  = 2048;

    const longint unsigned arctan_q32 [RotSteps] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680350, 5340245, 2670675, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430};

    logic signed [23:0] pose_x, pose_y;
    logic [31:0]        yaw, start_ang, step_ang;
    logic [15:0]        tol;

    int          beam;
    int          seen;
    int          seg;
    longint      first_x, first_y, prev_x, prev_y;
    t_out_word   expected_words [$];

    function automatic longint clamp24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Rotates (r*K, 0) by the beam angle and adds the pose.
    task automatic beam_to_global(input logic [15:0] r, input logic [31:0] ang,
                                  output longint gx, output longint gy);
        longint x, y, z, xs, ys;
        logic [31:0] a;
        logic [31:0] folded;
        x = longint'((64'(r) * 64'(GainQ30)) >> (30 - FracBits));
        y = 0;
        a = ang;
        folded = a + 32'h4000_0000;
        if (folded[31]) begin
            x = -x;
            a = a + 32'h8000_0000;
        end
        z = longint'($signed(a));
        for (int i = 0; i < RotSteps; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0) begin
                x = x - xs; y = y + ys; z = z - longint'(arctan_q32[i]);
            end else begin
                x = x + xs; y = y - ys; z = z + longint'(arctan_q32[i]);
            end
        end
        x = (x + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
        y = (y + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
        gx = clamp24(x + longint'(pose_x));
        gy = clamp24(y + longint'(pose_y));
    endtask

    function automatic bit apart(input longint ax, input longint ay,
                                 input longint bx, input longint by);
        longint dx, dy;
        dx = ax - bx;
        dy = ay - by;
        return (dx * dx + dy * dy) >= longint'(tol) * longint'(tol);
    endfunction

    task automatic predict_sample(input t_in_word w);
        t_out_word   pt, sm;
        logic [31:0] ang;
        longint      gx, gy;
        bit          opens, few, merge;
        int          total;
        if (w.range_valid) begin
            ang = start_ang + step_ang * 32'(beam) + yaw;
            beam_to_global(w.range_mm, ang, gx, gy);
            if (seen == 0) begin
                opens = 1;
                seg = 0;
                first_x = gx;
                first_y = gy;
            end else begin
                opens = apart(gx, gy, prev_x, prev_y);
                if (opens && seg < SegMax) seg++;
            end
            prev_x = gx;
            prev_y = gy;
            if (seen < 2) seen++;
            pt = '0;
            pt.global_x_mm = gx[23:0];
            pt.global_y_mm = gy[23:0];
            pt.segment_number = seg[10:0];
            pt.starts_segment = opens;
            pt.last_of_run = !w.end_of_scan;
            expected_words = {expected_words, pt};
        end
        beam = (beam + 1) % ScanLen;
        if (w.end_of_scan) begin
            few = seen < 2;
            total = 0;
            merge = 0;
            if (!few) begin
                total = seg + 1;
                if (total >= 2 && !apart(prev_x, prev_y, first_x, first_y)) begin
                    merge = 1;
                    total--;
                end
            end
            sm = '0;
            sm.result_kind = 1'b1;
            sm.segments_total = total[11:0];
            sm.wrap_merge = merge;
            sm.too_few_points = few;
            sm.last_of_run = 1'b1;
            expected_words = {expected_words, sm};
            beam = 0;
            seen = 0;
            seg = 0;
        end
    endtask

    task automatic check_field(input string name, input longint exp_v,
                               input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            pose_x <= '0; pose_y <= '0; yaw <= '0; start_ang <= '0; step_ang <= '0;
            tol <= 16'd175;
            beam = 0; seen = 0; seg = 0;
            first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
            expected_words.delete();
        end else begin
            if (i_valid && !o_stall) predict_sample(i_data);
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, o_data);
                    o_errors++;
                end else begin
                    e = expected_words.pop_front();
                    check_field("result_kind", e.result_kind, o_data.result_kind);
                    check_field("global_x_mm", e.global_x_mm, o_data.global_x_mm);
                    check_field("global_y_mm", e.global_y_mm, o_data.global_y_mm);
                    check_field("segment_number", e.segment_number, o_data.segment_number);
                    check_field("starts_segment", e.starts_segment, o_data.starts_segment);
                    check_field("segments_total", e.segments_total, o_data.segments_total);
                    check_field("wrap_merge", e.wrap_merge, o_data.wrap_merge);
                    check_field("too_few_points", e.too_few_points, o_data.too_few_points);
                    check_field("last_of_run", e.last_of_run, o_data.last_of_run);
                end
            end
            // Register writes take effect for samples accepted after this edge.
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_POSE_X: pose_x <= pwdata[23:0];
                    REG_POSE_Y: pose_y <= pwdata[23:0];
                    REG_YAW:    yaw <= pwdata;
                    REG_START:  start_ang <= pwdata;
                    REG_STEP:   step_ang <= pwdata;
                    REG_TOL:    tol <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_words.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

endmodule

### bench/lidar_scan_segmenter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_segmenter_unit_tb
// Drives beam samples and register settings into the scan segmenter, with
// random idle cycles on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module lidar_scan_segmenter_unit_tb;
    import lss_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_word   i_data;
    logic       o_valid;
    logic       i_stall;
    t_out_word  o_data;
    logic       psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;

    int errors;
    int pending;
    int samples_sent;
    bit send_idle;
    bit recv_idle;
    int hold_req;
    int hold_done;
    int stall_left;

    lidar_scan_segmenter_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lss_result_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stall after each word while recv_idle is set, plus one long hold.
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_done + 1;
            stall_left <= 400;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= (stall_left > 1);
        end else if (o_valid && !i_stall) begin
            n = recv_idle ? $urandom_range(0, 17) : 0;
            stall_left <= n;
            i_stall <= (n > 0);
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic load_settings(input logic [23:0] px, input logic [23:0] py,
                                 input logic [31:0] yw, input logic [31:0] st,
                                 input logic [31:0] sp, input logic [15:0] tl);
        reg_write(REG_POSE_X, {8'h00, px});
        reg_write(REG_POSE_Y, {8'h00, py});
        reg_write(REG_YAW, yw);
        reg_write(REG_START, st);
        reg_write(REG_STEP, sp);
        reg_write(REG_TOL, {16'h0000, tl});
    endtask

    task automatic send_sample(input logic [15:0] r, input bit ok, input bit last);
        int gap;
        gap = send_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{range_mm: r, range_valid: ok, end_of_scan: last};
        do @(posedge i_clk); while (o_stall);
        samples_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // A missing sample may still be in flight after the last word.
        repeat (60) @(posedge i_clk);
    endtask

    // One scan: mostly a smooth range walk with jumps, some missing samples.
    task automatic random_scan(input int len, input bit noisy);
        int r;
        r = $urandom_range(200, 60000);
        for (int k = 0; k < len; k++) begin
            if (noisy || $urandom_range(0, 19) == 0) r = $urandom_range(0, 65535);
            else r = r + $urandom_range(0, 300) - 150;
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
            send_sample(r[15:0], $urandom_range(0, 9) != 0, k == len - 1);
        end
    endtask

    initial begin
        int len;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        hold_req = 0;
        hold_done = 0;
        samples_sent = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: all beams point along x, so x equals the range.
        send_sample(16'd0, 1'b0, 1'b1);
        send_sample(16'd0, 1'b1, 1'b1);
        send_sample(16'd65535, 1'b1, 1'b0);
        send_sample(16'd0, 1'b1, 1'b0);
        send_sample(16'd65535, 1'b0, 1'b1);
        send_sample(16'd1000, 1'b1, 1'b0);
        send_sample(16'd1100, 1'b1, 1'b0);
        send_sample(16'd5000, 1'b1, 1'b0);
        send_sample(16'd1000, 1'b0, 1'b0);
        send_sample(16'd1050, 1'b1, 1'b1);
        send_sample(16'd1000, 1'b1, 1'b0);
        send_sample(16'd1000, 1'b1, 1'b1);
        send_sample(16'd100, 1'b1, 1'b0);
        send_sample(16'd9000, 1'b1, 1'b1);
        drain();

        // Extreme settings: saturation at both ends of the pose range.
        load_settings(24'h7FFFFF, 24'h800000, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000,
                      16'hFFFF);
        for (int k = 0; k < 8; k++) send_sample(16'hFFFF, 1'b1, k == 7);
        drain();
        load_settings(24'h800000, 24'h7FFFFF, 32'h4000_0000, 32'hC000_0000, 32'h1,
                      16'h0);
        for (int k = 0; k < 6; k++) send_sample(16'($urandom), 1'b1, k == 5);
        drain();

        // Long scan with many segments, sent back to back.
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int k = 0; k < 600; k++) send_sample(16'($urandom), 1'b1, k == 599);
        drain();

        for (int phase = 0; samples_sent < 1400; phase++) begin
            send_idle = (phase % 3) != 2;
            recv_idle = (phase % 4) != 3;
            load_settings(24'($urandom), 24'($urandom), $urandom, $urandom,
                          (phase % 2) ? $urandom : $urandom_range(0, 12000000),
                          16'((phase % 5 == 0) ? $urandom : $urandom_range(20, 600)));
            if (phase == 1) hold_req = hold_req + 1;
            for (int s = 0; s < 6; s++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(2, 40);
                random_scan(len, $urandom_range(0, 5) == 0);
            end
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
